// File: src/tjm_pkg.sv
// Package for the tilt-to-joystick mapper: widths, constants, register
// indexes, CORDIC angle table and the per-axis mapping functions.
// No dependencies.
package tjm_pkg;

  localparam int CORDIC_STAGES_DEF = 16;
  localparam int ANGLE_TABLE_LEN   = 24;

  localparam int ACC_W   = 16;          // sensor sample width
  localparam int SQ_W    = 32;          // sum of two squares
  localparam int SQ_IN_W = SQ_W + 8;    // sum scaled by 256 before the root
  localparam int SQRT_W  = SQ_IN_W / 2; // root width
  localparam int CW      = 24;          // CORDIC x/y width
  localparam int ZW      = 25;          // CORDIC angle accumulator width
  localparam int NW      = 21;          // slope numerator width
  localparam int RW      = 17;          // Q8.8 angle width
  localparam int CODE_W  = 12;

  localparam logic [CODE_W-1:0] MID_CODE = 12'd2048;
  localparam logic [CODE_W-1:0] MAX_CODE = 12'd4095;

  localparam logic [6:0] ROLL_D_LO  = 7'd50;
  localparam logic [6:0] ROLL_D_HI  = 7'd90;
  localparam logic [6:0] PITCH_D_LO = 7'd50;
  localparam logic [6:0] PITCH_D_HI = 7'd85;

  // ceil(2^32 / D): exact quotient for numerators below 2^19
  localparam logic [26:0] RECIP_50 = 27'(((64'd1 << 32) + 64'd49) / 64'd50);
  localparam logic [26:0] RECIP_90 = 27'(((64'd1 << 32) + 64'd89) / 64'd90);
  localparam logic [26:0] RECIP_85 = 27'(((64'd1 << 32) + 64'd84) / 64'd85);

  typedef enum logic [1:0] {
    REG_ROLL_LO,
    REG_ROLL_HI,
    REG_PITCH_LO,
    REG_PITCH_HI
  } cfg_idx_t;

  typedef struct packed {
    logic [7:0] roll_lo;
    logic [6:0] roll_hi;
    logic [7:0] pitch_lo;
    logic [6:0] pitch_hi;
  } cfg_t;

  // sideband that rides along with each sample
  typedef struct packed {
    logic valid;
    logic hover;
    logic zero_roll;
    logic zero_pitch;
  } side_t;

  typedef struct packed {
    logic signed [ACC_W-1:0] num_roll;
    logic signed [ACC_W-1:0] num_pitch;
  } num_t;

  typedef struct packed {
    logic                 mid;
    logic                 lo;
    logic signed [NW-1:0] n;
    logic signed [NW-1:0] d;
  } front_t;

  // round(atan(2^-i) * 180/3.14 * 65536)
  function automatic logic signed [ZW-1:0] atan_unit(input int i);
    logic signed [ZW-1:0] v;
    case (i)
      0:  v = 25'sd2950616;
      1:  v = 25'sd1741850;
      2:  v = 25'sd920346;
      3:  v = 25'sd467182;
      4:  v = 25'sd234498;
      5:  v = 25'sd117363;
      6:  v = 25'sd58696;
      7:  v = 25'sd29350;
      8:  v = 25'sd14675;
      9:  v = 25'sd7338;
      10: v = 25'sd3669;
      11: v = 25'sd1834;
      12: v = 25'sd917;
      13: v = 25'sd459;
      14: v = 25'sd229;
      15: v = 25'sd115;
      16: v = 25'sd57;
      17: v = 25'sd29;
      18: v = 25'sd14;
      19: v = 25'sd7;
      20: v = 25'sd4;
      21: v = 25'sd2;
      22: v = 25'sd1;
      default: v = 25'sd0;
    endcase
    return v;
  endfunction

  // Round angle to Q8.8, place it against the dead zone, form the numerator.
  function automatic front_t axis_front(input logic signed [ZW-1:0] z,
                                        input logic [7:0] lo,
                                        input logic [6:0] hi,
                                        input logic [6:0] d_lo,
                                        input logic [6:0] d_hi,
                                        input logic neg);
    logic signed [ZW-1:0] zr;
    logic signed [RW-1:0] r;
    logic signed [RW:0]   r18;
    logic signed [RW:0]   lo256;
    logic signed [RW:0]   hi256;
    logic signed [NW-1:0] r21;
    logic signed [NW-1:0] p8;
    front_t f;
    zr      = z + ZW'(128);
    r       = RW'(zr >>> 8);
    r18     = $signed({r[RW-1], r});
    lo256   = $signed({{2{lo[7]}}, lo, 8'd0});
    hi256   = $signed({3'd0, hi, 8'd0});
    f.lo    = r18 < lo256;
    f.mid   = !f.lo && (r18 <= hi256);
    f.d     = f.lo ? $signed({14'd0, d_lo}) : $signed({14'd0, d_hi});
    r21     = $signed({{(NW-RW){r[RW-1]}}, r});
    p8      = r21 <<< 3;
    f.n     = (f.d <<< 11) + (neg ? -p8 : p8);
    return f;
  endfunction

  // Truncated n/D clamped to the code range, or the mid code inside the dead zone.
  function automatic logic [CODE_W-1:0] axis_code(input front_t f,
                                                  input logic [26:0] m_lo,
                                                  input logic [26:0] m_hi);
    logic [26:0]          m;
    logic [45:0]          p;
    logic signed [NW-1:0] lim;
    logic [CODE_W-1:0]    c;
    m   = f.lo ? m_lo : m_hi;
    lim = f.d <<< 12;
    p   = 46'(f.n[18:0]) * 46'(m);
    if (f.mid) begin
      c = MID_CODE;
    end else if (f.n <= 0) begin
      c = '0;
    end else if (f.n >= lim) begin
      c = MAX_CODE;
    end else begin
      c = p[43:32];
    end
    return c;
  endfunction

endpackage

// File: src/tjm_in_if.sv
// Input channel: one accelerometer sample and the mode bit.
// Depends on tjm_pkg for widths.
interface tjm_in_if;
  logic                            valid;
  logic                            ready;
  logic signed [tjm_pkg::ACC_W-1:0] accel_x;
  logic signed [tjm_pkg::ACC_W-1:0] accel_y;
  logic signed [tjm_pkg::ACC_W-1:0] accel_z;
  logic                            hover_mode;

  modport source (output valid, accel_x, accel_y, accel_z, hover_mode, input ready);
  modport sink   (input valid, accel_x, accel_y, accel_z, hover_mode, output ready);
endinterface

// File: src/tjm_out_if.sv
// Result channel: four DAC codes.
// Depends on tjm_pkg for widths.
interface tjm_out_if;
  logic                         valid;
  logic                         ready;
  logic [tjm_pkg::CODE_W-1:0]   channel_a;
  logic [tjm_pkg::CODE_W-1:0]   channel_b;
  logic [tjm_pkg::CODE_W-1:0]   channel_c;
  logic [tjm_pkg::CODE_W-1:0]   channel_d;

  modport source (output valid, channel_a, channel_b, channel_c, channel_d, input ready);
  modport sink   (input valid, channel_a, channel_b, channel_c, channel_d, output ready);
endinterface

// File: src/tjm_sqrt.sv
// Pipelined integer square root, one result bit per stage.
// Depends on tjm_pkg.
module tjm_sqrt (
  input  logic                         clk,
  input  logic                         en,
  input  logic [tjm_pkg::SQ_IN_W-1:0]  v_i,
  output logic [tjm_pkg::SQRT_W-1:0]   root_o
);
  localparam int IW = tjm_pkg::SQ_IN_W;
  localparam int OW = tjm_pkg::SQRT_W;

  logic [IW-1:0] rem_r  [OW];
  logic [OW-1:0] root_r [OW];

  for (genvar k = 0; k < OW; k++) begin : g_bit
    localparam int B = OW - 1 - k;
    logic [IW-1:0] rem_in;
    logic [OW-1:0] root_in;
    logic [IW:0]   trial;

    if (k == 0) begin : g_first
      assign rem_in  = v_i;
      assign root_in = '0;
    end else begin : g_next
      assign rem_in  = rem_r[k-1];
      assign root_in = root_r[k-1];
    end

    // (r + 2^B)^2 - r^2
    assign trial = ((IW+1)'(root_in) << (B + 1)) | ((IW+1)'(1) << (2 * B));

    always_ff @(posedge clk) begin
      if (en) begin
        if ({1'b0, rem_in} >= trial) begin
          rem_r[k]  <= rem_in - trial[IW-1:0];
          root_r[k] <= root_in | (OW'(1) << B);
        end else begin
          rem_r[k]  <= rem_in;
          root_r[k] <= root_in;
        end
      end
    end
  end

  assign root_o = root_r[OW-1];
endmodule

// File: src/tjm_cordic.sv
// Unrolled vectoring CORDIC, one micro-rotation per register stage.
// Depends on tjm_pkg for widths and the angle table.
module tjm_cordic #(
  parameter int STAGES = tjm_pkg::CORDIC_STAGES_DEF
) (
  input  logic                             clk,
  input  logic                             en,
  input  logic [tjm_pkg::SQRT_W-1:0]       a_i,
  input  logic signed [tjm_pkg::CW-1:0]    b_i,
  output logic signed [tjm_pkg::ZW-1:0]    z_o
);
  localparam int CW = tjm_pkg::CW;
  localparam int ZW = tjm_pkg::ZW;

  logic signed [CW-1:0] a_r [STAGES];
  logic signed [CW-1:0] b_r [STAGES];
  logic signed [ZW-1:0] z_r [STAGES];

  for (genvar k = 0; k < STAGES; k++) begin : g_stage
    logic signed [CW-1:0] a_in;
    logic signed [CW-1:0] b_in;
    logic signed [ZW-1:0] z_in;
    logic signed [CW-1:0] da;
    logic signed [CW-1:0] db;

    if (k == 0) begin : g_first
      assign a_in = $signed(CW'(a_i));
      assign b_in = b_i;
      assign z_in = '0;
    end else begin : g_next
      assign a_in = a_r[k-1];
      assign b_in = b_r[k-1];
      assign z_in = z_r[k-1];
    end

    assign da = b_in >>> k;
    assign db = a_in >>> k;

    always_ff @(posedge clk) begin
      if (en) begin
        if (b_in >= 0) begin
          a_r[k] <= a_in + da;
          b_r[k] <= b_in - db;
          z_r[k] <= z_in + tjm_pkg::atan_unit(k);
        end else begin
          a_r[k] <= a_in - da;
          b_r[k] <= b_in + db;
          z_r[k] <= z_in - tjm_pkg::atan_unit(k);
        end
      end
    end
  end

  assign z_o = z_r[STAGES-1];
endmodule

// File: src/tjm_map.sv
// Dead-zone mapping of roll and pitch to DAC codes, two register stages:
// compare and numerator, then reciprocal multiply and clamp.
// Depends on tjm_pkg.
module tjm_map (
  input  logic                           clk,
  input  logic                           en,
  input  tjm_pkg::cfg_t                  cfg,
  input  logic signed [tjm_pkg::ZW-1:0]  z_roll_i,
  input  logic signed [tjm_pkg::ZW-1:0]  z_pitch_i,
  output logic [tjm_pkg::CODE_W-1:0]     roll_code_o,
  output logic [tjm_pkg::CODE_W-1:0]     pitch_code_o
);
  tjm_pkg::front_t              roll_f_r;
  tjm_pkg::front_t              pitch_f_r;
  logic [tjm_pkg::CODE_W-1:0]   roll_code_r;
  logic [tjm_pkg::CODE_W-1:0]   pitch_code_r;

  always_ff @(posedge clk) begin
    if (en) begin
      // roll slopes fall with angle, pitch slopes rise
      roll_f_r     <= tjm_pkg::axis_front(z_roll_i, cfg.roll_lo, cfg.roll_hi,
                                          tjm_pkg::ROLL_D_LO, tjm_pkg::ROLL_D_HI, 1'b1);
      pitch_f_r    <= tjm_pkg::axis_front(z_pitch_i, cfg.pitch_lo, cfg.pitch_hi,
                                          tjm_pkg::PITCH_D_LO, tjm_pkg::PITCH_D_HI, 1'b0);
      roll_code_r  <= tjm_pkg::axis_code(roll_f_r, tjm_pkg::RECIP_50, tjm_pkg::RECIP_90);
      pitch_code_r <= tjm_pkg::axis_code(pitch_f_r, tjm_pkg::RECIP_50, tjm_pkg::RECIP_85);
    end
  end

  assign roll_code_o  = roll_code_r;
  assign pitch_code_o = pitch_code_r;
endmodule

// File: src/tilt_to_joystick_mapper.sv
// Top level of the tilt-to-joystick mapper: squares, root, CORDIC, mapping.
// Depends on tjm_pkg, tjm_in_if, tjm_out_if, tjm_sqrt, tjm_cordic, tjm_map.
//
//   channel | dir | handshake    | payload
//   in_ch   | in  | valid/ready  | accel_x, accel_y, accel_z, hover_mode
//   out_ch  | out | valid/ready  | channel_a .. channel_d
//   cfg     | in  | cfg_we       | cfg_index, cfg_data
//
// One sample per cycle while the output is not stalled; the pipeline holds 2 square/sum
// stages, 20 root stages, the CORDIC stages, 2 mapping stages and the output register.
// Synchronous active-low reset clears valid bits and sets dead-zone registers to defaults.
// The whole pipeline advances when the output register is empty or taken,
// so a stall holds every stage in place.
module tilt_to_joystick_mapper #(
  parameter int CORDIC_STAGES = tjm_pkg::CORDIC_STAGES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  tjm_in_if.sink      in_ch,
  tjm_out_if.source   out_ch,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_data
);
  localparam int SQ_W     = tjm_pkg::SQ_W;
  localparam int ACC_W    = tjm_pkg::ACC_W;
  localparam int SQRT_W   = tjm_pkg::SQRT_W;
  localparam int CW       = tjm_pkg::CW;
  localparam int ZW       = tjm_pkg::ZW;
  localparam int CORD_END = SQRT_W + CORDIC_STAGES - 1;
  localparam int SIDE_LEN = SQRT_W + CORDIC_STAGES + 2;

  tjm_pkg::cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.roll_lo  <= 8'hF6;
      cfg_r.roll_hi  <= 7'd30;
      cfg_r.pitch_lo <= 8'hF1;
      cfg_r.pitch_hi <= 7'd15;
    end else if (cfg_we) begin
      case (tjm_pkg::cfg_idx_t'(cfg_index))
        tjm_pkg::REG_ROLL_LO:  cfg_r.roll_lo  <= cfg_data;
        tjm_pkg::REG_ROLL_HI:  cfg_r.roll_hi  <= cfg_data[6:0];
        tjm_pkg::REG_PITCH_LO: cfg_r.pitch_lo <= cfg_data;
        tjm_pkg::REG_PITCH_HI: cfg_r.pitch_hi <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

  logic en;
  logic out_valid_r;
  assign en          = !out_valid_r || out_ch.ready;
  assign in_ch.ready = en;

  // stage 1: squares
  logic                    v1_r;
  logic                    hov1_r;
  logic [SQ_W-1:0]         xx_r, yy_r, zz_r;
  logic signed [ACC_W-1:0] x1_r, y1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      hov1_r <= in_ch.hover_mode;
      xx_r   <= SQ_W'(in_ch.accel_x * in_ch.accel_x);
      yy_r   <= SQ_W'(in_ch.accel_y * in_ch.accel_y);
      zz_r   <= SQ_W'(in_ch.accel_z * in_ch.accel_z);
      x1_r   <= in_ch.accel_x;
      y1_r   <= in_ch.accel_y;
    end
  end

  // stage 2: sums and all-zero detection
  tjm_pkg::side_t  side2_r;
  tjm_pkg::num_t   num2_r;
  logic [SQ_W-1:0] sum_roll_r, sum_pitch_r;
  logic [SQ_W-1:0] sum_roll, sum_pitch;

  assign sum_roll  = xx_r + zz_r;
  assign sum_pitch = yy_r + zz_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      side2_r.valid <= 1'b0;
    end else if (en) begin
      side2_r.valid      <= v1_r;
      side2_r.hover      <= hov1_r;
      side2_r.zero_roll  <= (sum_roll == '0) && (y1_r == '0);
      side2_r.zero_pitch <= (sum_pitch == '0) && (x1_r == '0);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sum_roll_r         <= sum_roll;
      sum_pitch_r        <= sum_pitch;
      num2_r.num_roll    <= y1_r;
      num2_r.num_pitch   <= x1_r;
    end
  end

  // sideband and numerator delay lines
  tjm_pkg::side_t side_r [SIDE_LEN];
  tjm_pkg::num_t  num_r  [SQRT_W];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < SIDE_LEN; i++) begin
        side_r[i].valid <= 1'b0;
      end
    end else if (en) begin
      side_r[0] <= side2_r;
      for (int i = 1; i < SIDE_LEN; i++) begin
        side_r[i] <= side_r[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      num_r[0] <= num2_r;
      for (int i = 1; i < SQRT_W; i++) begin
        num_r[i] <= num_r[i-1];
      end
    end
  end

  // magnitudes
  logic [SQRT_W-1:0] mag_roll, mag_pitch;

  tjm_sqrt u_sqrt_roll (
    .clk    (clk),
    .en     (en),
    .v_i    ({sum_roll_r, 8'd0}),
    .root_o (mag_roll)
  );

  tjm_sqrt u_sqrt_pitch (
    .clk    (clk),
    .en     (en),
    .v_i    ({sum_pitch_r, 8'd0}),
    .root_o (mag_pitch)
  );

  // numerator scaled by 16
  logic signed [CW-1:0] b_roll, b_pitch;
  tjm_pkg::num_t        num_q;

  assign num_q   = num_r[SQRT_W-1];
  assign b_roll  = $signed({{(CW-ACC_W-4){num_q.num_roll[ACC_W-1]}}, num_q.num_roll, 4'd0});
  assign b_pitch = $signed({{(CW-ACC_W-4){num_q.num_pitch[ACC_W-1]}}, num_q.num_pitch, 4'd0});

  logic signed [ZW-1:0] z_roll, z_pitch;

  tjm_cordic #(.STAGES(CORDIC_STAGES)) u_cordic_roll (
    .clk (clk),
    .en  (en),
    .a_i (mag_roll),
    .b_i (b_roll),
    .z_o (z_roll)
  );

  tjm_cordic #(.STAGES(CORDIC_STAGES)) u_cordic_pitch (
    .clk (clk),
    .en  (en),
    .a_i (mag_pitch),
    .b_i (b_pitch),
    .z_o (z_pitch)
  );

  // all-zero vector gives angle 0
  logic signed [ZW-1:0] z_roll_sel, z_pitch_sel;
  assign z_roll_sel  = side_r[CORD_END].zero_roll  ? '0 : z_roll;
  assign z_pitch_sel = side_r[CORD_END].zero_pitch ? '0 : z_pitch;

  logic [tjm_pkg::CODE_W-1:0] roll_code, pitch_code;

  tjm_map u_map (
    .clk          (clk),
    .en           (en),
    .cfg          (cfg_r),
    .z_roll_i     (z_roll_sel),
    .z_pitch_i    (z_pitch_sel),
    .roll_code_o  (roll_code),
    .pitch_code_o (pitch_code)
  );

  // output register with channel routing
  logic [tjm_pkg::CODE_W-1:0] ch_a_r, ch_b_r, ch_c_r, ch_d_r;
  logic                       hov_q;
  assign hov_q = side_r[SIDE_LEN-1].hover;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= side_r[SIDE_LEN-1].valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ch_a_r <= hov_q ? tjm_pkg::MID_CODE : roll_code;
      ch_b_r <= hov_q ? tjm_pkg::MID_CODE : pitch_code;
      ch_c_r <= hov_q ? pitch_code : tjm_pkg::MID_CODE;
      ch_d_r <= hov_q ? roll_code : tjm_pkg::MID_CODE;
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.channel_a = ch_a_r;
  assign out_ch.channel_b = ch_b_r;
  assign out_ch.channel_c = ch_c_r;
  assign out_ch.channel_d = ch_d_r;
endmodule
